FILE: hdl/rbsi_pkg.sv
// rbsi_pkg: shared widths, constants and pipeline item types for the ray/box slab test
// no dependencies
package rbsi_pkg;

   localparam int CoordBits = 32;
   localparam int FracBits  = 16;
   localparam int QuoBits   = CoordBits + 1;
   localparam int NumAxes   = 3;
   localparam int NumLanes  = 2 * NumAxes;
   localparam int NumFields = 4 * NumAxes;
   localparam int InBits    = NumFields * CoordBits;
   localparam int OutBits   = 2 * CoordBits;
   localparam int HeadBits  = FracBits - 1;
   localparam int TailBits  = CoordBits - HeadBits;

   localparam logic [CoordBits-1:0] TMax   = {1'b0, {(CoordBits-1){1'b1}}};
   localparam logic [QuoBits-1:0]   SatMag = QuoBits'(1) << (CoordBits - 1);

   typedef struct packed {
      logic [CoordBits-1:0] den;
      logic [CoordBits-1:0] rem;
      logic [QuoBits-1:0]   dvd;
      logic [QuoBits-1:0]   quo;
      logic                 neg;
      logic                 ovf;
   } lane_type;

   typedef struct packed {
      lane_type [NumLanes-1:0] lane;
      logic [NumAxes-1:0]      skip;
   } div_item_type;

endpackage

FILE: hdl/rbsi_prep.sv
// rbsi_prep: two stages forming slab numerators, magnitudes, signs and overflow flags
// depends on rbsi_pkg
module rbsi_prep
   import rbsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [InBits-1:0] in_data,
   output logic              out_valid,
   output div_item_type      out_item
);

   logic [CoordBits:0]   num_ff [NumLanes];
   logic [CoordBits:0]   num_in [NumLanes];
   logic [CoordBits-1:0] den_ff [NumAxes];
   logic [CoordBits-1:0] den_in [NumAxes];
   logic [NumAxes-1:0]   skip_ff, skip_in;
   logic                 vld1_ff, vld2_ff;
   div_item_type         item_ff, item_in;

   always_comb begin
      logic [CoordBits-1:0] org;
      logic [CoordBits-1:0] crn;
      for (int l = 0; l < NumLanes; l++) begin
         org = in_data[(l % NumAxes)*CoordBits +: CoordBits];
         crn = in_data[(2*NumAxes + l)*CoordBits +: CoordBits];
         num_in[l] = {crn[CoordBits-1], crn} - {org[CoordBits-1], org};
      end
      for (int a = 0; a < NumAxes; a++) begin
         den_in[a]  = in_data[(NumAxes + a)*CoordBits +: CoordBits];
         skip_in[a] = (den_in[a] == '0);
      end
   end

   always_comb begin
      logic [CoordBits:0]   nneg;
      logic [CoordBits-1:0] an;
      logic [CoordBits-1:0] ad;
      logic [CoordBits-1:0] dneg;
      for (int l = 0; l < NumLanes; l++) begin
         nneg = '0 - num_ff[l];
         dneg = '0 - den_ff[l % NumAxes];
         an   = num_ff[l][CoordBits] ? nneg[CoordBits-1:0] : num_ff[l][CoordBits-1:0];
         ad   = den_ff[l % NumAxes][CoordBits-1] ? dneg : den_ff[l % NumAxes];
         item_in.lane[l].den = ad;
         item_in.lane[l].rem = CoordBits'(an[CoordBits-1:TailBits]);
         item_in.lane[l].dvd = {an[TailBits-1:0], {FracBits{1'b0}}};
         item_in.lane[l].quo = '0;
         item_in.lane[l].neg = num_ff[l][CoordBits] ^ den_ff[l % NumAxes][CoordBits-1];
         item_in.lane[l].ovf = (CoordBits'(an[CoordBits-1:TailBits]) >= ad);
      end
      item_in.skip = skip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         skip_ff <= skip_in;
         item_ff <= item_in;
      end
   end

   assign out_valid = vld2_ff;
   assign out_item  = item_ff;

endmodule

FILE: hdl/rbsi_div_step.sv
// rbsi_div_step: one restoring division step for all six slab lanes, registered
// depends on rbsi_pkg
module rbsi_div_step
   import rbsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  div_item_type in_item,
   output logic         out_valid,
   output div_item_type out_item
);

   logic         vld_ff;
   div_item_type item_ff, item_in;

   always_comb begin
      logic [CoordBits-1:0] shifted;
      logic                 take;
      item_in = in_item;
      for (int l = 0; l < NumLanes; l++) begin
         shifted = {in_item.lane[l].rem[CoordBits-2:0], in_item.lane[l].dvd[QuoBits-1]};
         take    = (shifted >= in_item.lane[l].den);
         item_in.lane[l].rem = take ? shifted - in_item.lane[l].den : shifted;
         item_in.lane[l].dvd = {in_item.lane[l].dvd[QuoBits-2:0], 1'b0};
         item_in.lane[l].quo = {in_item.lane[l].quo[QuoBits-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;

endmodule

FILE: hdl/rbsi_reduce.sv
// rbsi_reduce: saturation, per-axis min/max, near/far reduction and hit output register
// depends on rbsi_pkg
module rbsi_reduce
   import rbsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  div_item_type         in_item,
   output logic                 out_valid,
   output logic                 hit,
   output logic [CoordBits-2:0] t_near,
   output logic [CoordBits-1:0] t_far
);

   logic signed [CoordBits-1:0] k_ff [NumLanes];
   logic signed [CoordBits-1:0] k_in [NumLanes];
   logic [NumAxes-1:0]          skip_ff;
   logic signed [CoordBits-1:0] kmin_ff [NumAxes];
   logic signed [CoordBits-1:0] kmin_in [NumAxes];
   logic signed [CoordBits-1:0] kmax_ff [NumAxes];
   logic signed [CoordBits-1:0] kmax_in [NumAxes];
   logic signed [CoordBits-1:0] near_ff, near_in, far_ff, far_in;
   logic signed [CoordBits-1:0] onear_ff, ofar_ff;
   logic                        hit_ff, hit_in;
   logic                        vld1_ff, vld2_ff, vld3_ff, vld4_ff;

   // saturate quotient and apply sign
   always_comb begin
      logic [QuoBits-1:0] mag;
      logic [QuoBits-1:0] mneg;
      for (int l = 0; l < NumLanes; l++) begin
         mag  = (in_item.lane[l].ovf || in_item.lane[l].quo > SatMag) ? SatMag
                                                                     : in_item.lane[l].quo;
         mneg = '0 - mag;
         if (in_item.lane[l].neg) begin
            k_in[l] = $signed(mneg[CoordBits-1:0]);
         end else if (mag == SatMag) begin
            k_in[l] = $signed(TMax);
         end else begin
            k_in[l] = $signed(mag[CoordBits-1:0]);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NumAxes; a++) begin
         if (skip_ff[a]) begin
            kmin_in[a] = '0;
            kmax_in[a] = $signed(TMax);
         end else if (k_ff[a] < k_ff[a+NumAxes]) begin
            kmin_in[a] = k_ff[a];
            kmax_in[a] = k_ff[a+NumAxes];
         end else begin
            kmin_in[a] = k_ff[a+NumAxes];
            kmax_in[a] = k_ff[a];
         end
      end
   end

   always_comb begin
      near_in = '0;
      far_in  = $signed(TMax);
      for (int a = 0; a < NumAxes; a++) begin
         if (kmin_ff[a] > near_in) begin
            near_in = kmin_ff[a];
         end
         if (kmax_ff[a] < far_in) begin
            far_in = kmax_ff[a];
         end
      end
      hit_in = (far_ff > 0) && (near_ff < far_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff     <= k_in;
         skip_ff  <= in_item.skip;
         kmin_ff  <= kmin_in;
         kmax_ff  <= kmax_in;
         near_ff  <= near_in;
         far_ff   <= far_in;
         onear_ff <= near_ff;
         ofar_ff  <= far_ff;
         hit_ff   <= hit_in;
      end
   end

   assign out_valid = vld4_ff;
   assign hit       = hit_ff;
   assign t_near    = onear_ff[CoordBits-2:0];
   assign t_far     = ofar_ff;

endmodule

FILE: hdl/ray_box_slab_intersect.sv
// ray_box_slab_intersect: top level, prep stages, bit-serial divider pipeline and reduction
// depends on rbsi_pkg, rbsi_prep, rbsi_div_step, rbsi_reduce
//
// channel   dir   beat contents
// req_      in    origin xyz, dir xyz, box_lo xyz, box_hi xyz
// rsp_      out   hit, t_near, t_far
//
// one beat accepted per clock while the output is not stalled
// the divider chain yields one quotient bit per stage and is shared by six slab lanes
// reset clears all stage valid bits; no memories
// a stalled output holds the whole pipeline; nothing is lost or repeated
module ray_box_slab_intersect
   import rbsi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
   input  logic [InBits-1:0]  req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // hit, t_near, t_far
   output logic [OutBits-1:0] rsp_tdata
);

   logic                 en;
   logic                 vld  [QuoBits+1];
   div_item_type         item [QuoBits+1];
   logic                 hit;
   logic [CoordBits-2:0] t_near;
   logic [CoordBits-1:0] t_far;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   rbsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (vld[0]),
      .out_item  (item[0])
   );

   for (genvar s = 0; s < QuoBits; s++) begin : g_div
      rbsi_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld[s]),
         .in_item   (item[s]),
         .out_valid (vld[s+1]),
         .out_item  (item[s+1])
      );
   end

   rbsi_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld[QuoBits]),
      .in_item   (item[QuoBits]),
      .out_valid (rsp_tvalid),
      .hit       (hit),
      .t_near    (t_near),
      .t_far     (t_far)
   );

   assign rsp_tdata = {t_far, t_near, hit};

endmodule
